FILE: rtl/jse_pkg.sv
// Shared types, character constants and helpers of the JSON string escaper.
package jse_pkg;

   // Body of one command: what the back end prints between the optional quotes.
   typedef enum logic [2:0] {
      BODY_NONE,
      BODY_CHAR,
      BODY_U16,
      BODY_PAIR,
      BODY_RAW,
      BODY_ERR
   } body_type;

   // At most one command handed from the front end to the back end per input byte.
   typedef struct packed {
      logic        open_quote;
      body_type    body;
      logic [3:0]  body_len;
      logic [31:0] data;
      logic        close_quote;
   } cmd_type;

   // Phase of the back end within one command.
   typedef enum logic [1:0] {
      PH_OPEN,
      PH_BODY,
      PH_CLOSE
   } phase_type;

   // Register indexes of the configuration port.
   localparam logic CSR_ESC_NON_ASCII = 1'b0;
   localparam logic CSR_ESC_NON_BMP   = 1'b1;

   // Characters of the JSON text.
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_U      = 8'h75;
   localparam logic [7:0] CHAR_ERR    = 8'h00;

   // Body lengths in characters.
   localparam logic [3:0] LEN_ONE  = 4'd1;
   localparam logic [3:0] LEN_U16  = 4'd6;
   localparam logic [3:0] LEN_PAIR = 4'd12;

   // Uppercase hex digit of a nibble.
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] ext;
      ext = {4'h0, nib};
      if (nib < 4'd10) begin
         return 8'h30 + ext;
      end
      return 8'h37 + ext;
   endfunction

endpackage

FILE: rtl/jse_if.sv
// Channel interfaces of the escaper: raw byte input and JSON character output.
interface jse_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface jse_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       run_end;
   logic       text_end;
   logic       bad_utf8;

   modport source (output valid, output out_char, output run_end, output text_end,
                   output bad_utf8, input ready);
   modport sink   (input valid, input out_char, input run_end, input text_end,
                   input bad_utf8, output ready);
endinterface

FILE: rtl/jse_front.sv
// Front end: accepts input bytes, tracks UTF-8 sequences and issues print commands.
module jse_front
   import jse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   jse_req_if.sink req,
   input  logic    csr_wr_en,
   input  logic    csr_index,
   input  logic    csr_data,
   output logic    push_valid,
   input  logic    push_ready,
   output cmd_type push_cmd
);

   logic            esc_non_ascii_ff;
   logic            esc_non_bmp_ff;
   logic [2:0][7:0] held_bytes_ff, held_bytes_in;
   logic [1:0]      bytes_needed_ff, bytes_needed_in;
   logic [1:0]      bytes_held_ff, bytes_held_in;
   logic            inside_text_ff, inside_text_in;
   logic            dropping_ff, dropping_in;

   logic            accept;
   logic [7:0]      b;
   logic            last;
   logic [3:0][7:0] seq;
   logic [1:0]      len_m1;
   logic [20:0]     cp2, cp3, cp4;
   logic [25:0]     dval;
   logic [15:0]     hi_word, lo_word;
   logic            esc;
   logic            error;
   cmd_type         cmd;

   assign req.ready = push_ready;
   assign accept    = req.valid && push_ready;
   assign b         = req.in_byte;
   assign last      = req.in_last;

   // Completed sequence: held bytes with the current byte placed after them.
   always_comb begin
      len_m1 = (bytes_held_ff == 2'd0) ? 2'd1 : bytes_held_ff;
      seq = {8'h00, held_bytes_ff};
      seq[len_m1] = b;
      cp2 = {10'b0, seq[0][4:0], seq[1][5:0]};
      cp3 = {5'b0, seq[0][3:0], seq[1][5:0], seq[2][5:0]};
      cp4 = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
      dval = {5'b0, cp4} - 26'h0010000;
      hi_word = 16'hD800 + dval[25:10];
      lo_word = 16'hDC00 + {6'b0, dval[9:0]};
      esc = esc_non_ascii_ff || ((len_m1 == 2'd3) && esc_non_bmp_ff);
   end

   // Classification of the byte and the next sequence state.
   always_comb begin
      held_bytes_in   = held_bytes_ff;
      bytes_needed_in = bytes_needed_ff;
      bytes_held_in   = bytes_held_ff;
      inside_text_in  = inside_text_ff;
      dropping_in     = dropping_ff;
      error           = 1'b0;
      cmd.open_quote  = !inside_text_ff;
      cmd.body        = BODY_NONE;
      cmd.body_len    = LEN_ONE;
      cmd.data        = 32'h0;
      cmd.close_quote = 1'b0;

      if (dropping_ff) begin
         cmd.open_quote = 1'b0;
         if (last) begin
            dropping_in     = 1'b0;
            inside_text_in  = 1'b0;
            bytes_needed_in = 2'd0;
            bytes_held_in   = 2'd0;
         end
      end else begin
         inside_text_in = 1'b1;
         if (bytes_needed_ff == 2'd0) begin
            if (b <= 8'h1F) begin
               cmd.body     = BODY_U16;
               cmd.body_len = LEN_U16;
               cmd.data     = {24'h0, b};
            end else if (b < 8'h80) begin
               cmd.body = BODY_CHAR;
               cmd.data = {24'h0, b};
            end else if (b < 8'hC0) begin
               error = 1'b1;
            end else if (last) begin
               error = 1'b1;
            end else begin
               held_bytes_in[0] = b;
               bytes_held_in    = 2'd1;
               bytes_needed_in  = (b < 8'hE0) ? 2'd1 : ((b < 8'hF0) ? 2'd2 : 2'd3);
            end
         end else if (bytes_needed_ff > 2'd1) begin
            if (last) begin
               error = 1'b1;
            end else begin
               if (bytes_held_ff < 2'd3) begin
                  held_bytes_in[bytes_held_ff] = b;
               end
               bytes_held_in   = bytes_held_ff + 2'd1;
               bytes_needed_in = bytes_needed_ff - 2'd1;
            end
         end else begin
            bytes_needed_in = 2'd0;
            bytes_held_in   = 2'd0;
            if (!esc) begin
               cmd.body     = BODY_RAW;
               cmd.body_len = {2'b00, len_m1} + 4'd1;
               cmd.data     = seq;
            end else if (len_m1 == 2'd3) begin
               cmd.body     = BODY_PAIR;
               cmd.body_len = LEN_PAIR;
               cmd.data     = {hi_word, lo_word};
            end else if (len_m1 == 2'd2) begin
               cmd.body     = BODY_U16;
               cmd.body_len = LEN_U16;
               cmd.data     = {16'h0, cp3[15:0]};
            end else begin
               cmd.body     = BODY_U16;
               cmd.body_len = LEN_U16;
               cmd.data     = {16'h0, cp2[15:0]};
            end
         end

         if (error) begin
            cmd.body        = BODY_ERR;
            cmd.body_len    = LEN_ONE;
            bytes_needed_in = 2'd0;
            bytes_held_in   = 2'd0;
            if (last) begin
               inside_text_in = 1'b0;
            end else begin
               dropping_in = 1'b1;
            end
         end else if (last) begin
            cmd.close_quote = 1'b1;
            inside_text_in  = 1'b0;
         end
      end
   end

   assign push_cmd   = cmd;
   assign push_valid = accept && (cmd.open_quote || cmd.close_quote || (cmd.body != BODY_NONE));

   // Sequence state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         esc_non_ascii_ff <= 1'b0;
         esc_non_bmp_ff   <= 1'b0;
         held_bytes_ff    <= '0;
         bytes_needed_ff  <= 2'd0;
         bytes_held_ff    <= 2'd0;
         inside_text_ff   <= 1'b0;
         dropping_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_ESC_NON_ASCII) begin
               esc_non_ascii_ff <= csr_data;
            end
            if (csr_index == CSR_ESC_NON_BMP) begin
               esc_non_bmp_ff <= csr_data;
            end
         end
         if (accept) begin
            held_bytes_ff   <= held_bytes_in;
            bytes_needed_ff <= bytes_needed_in;
            bytes_held_ff   <= bytes_held_in;
            inside_text_ff  <= inside_text_in;
            dropping_ff     <= dropping_in;
         end
      end
   end

endmodule

FILE: rtl/jse_queue.sv
// Command queue between the front end and the back end.
module jse_queue
   import jse_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cmd_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CNT_FULL;
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: rtl/jse_back.sv
// Back end: expands each command into JSON characters, one per cycle while the output accepts them.
module jse_back
   import jse_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   output logic      pop_ready,
   input  cmd_type   pop_cmd,
   jse_rsp_if.source rsp
);

   cmd_type    cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   phase_type  phase_ff, phase_in;
   logic [3:0] idx_ff, idx_in;

   logic       rsp_valid_ff;
   logic [7:0] out_char_ff;
   logic       run_end_ff, text_end_ff, bad_utf8_ff;

   logic       emit;
   logic       seg_last, cmd_last;
   logic [7:0] ch;
   logic       tend, bad;
   logic       load;
   logic       second_word;
   logic [3:0] sub;
   logic [15:0] word;
   logic [1:0] byte_sel;

   assign emit = cur_valid_ff && (!rsp_valid_ff || rsp.ready);

   // Character for the current phase and position.
   always_comb begin
      ch          = CHAR_QUOTE;
      tend        = 1'b0;
      bad         = 1'b0;
      seg_last    = 1'b1;
      cmd_last    = 1'b0;
      second_word = (cur_ff.body == BODY_PAIR) && (idx_ff >= 4'd6);
      sub         = second_word ? idx_ff - 4'd6 : idx_ff;
      word        = (cur_ff.body == BODY_PAIR && !second_word) ? cur_ff.data[31:16]
                                                              : cur_ff.data[15:0];
      byte_sel    = idx_ff[1:0];
      case (phase_ff)
         PH_OPEN: begin
            cmd_last = (cur_ff.body == BODY_NONE) && !cur_ff.close_quote;
         end
         PH_BODY: begin
            seg_last = idx_ff == (cur_ff.body_len - 4'd1);
            cmd_last = seg_last && !cur_ff.close_quote;
            case (cur_ff.body)
               BODY_CHAR: ch = cur_ff.data[7:0];
               BODY_RAW:  ch = cur_ff.data[byte_sel*8 +: 8];
               BODY_ERR: begin
                  ch   = CHAR_ERR;
                  tend = 1'b1;
                  bad  = 1'b1;
               end
               BODY_U16, BODY_PAIR: begin
                  case (sub)
                     4'd0:    ch = CHAR_BSLASH;
                     4'd1:    ch = CHAR_U;
                     4'd2:    ch = hex_char(word[15:12]);
                     4'd3:    ch = hex_char(word[11:8]);
                     4'd4:    ch = hex_char(word[7:4]);
                     default: ch = hex_char(word[3:0]);
                  endcase
               end
               default: ch = CHAR_ERR;
            endcase
         end
         PH_CLOSE: begin
            tend     = 1'b1;
            cmd_last = 1'b1;
         end
         default: begin
            cmd_last = 1'b1;
         end
      endcase
   end

   assign load      = pop_valid && (!cur_valid_ff || (emit && cmd_last));
   assign pop_ready = load;

   // Next phase and position.
   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      if (load) begin
         cur_in       = pop_cmd;
         cur_valid_in = 1'b1;
         idx_in       = 4'd0;
         if (pop_cmd.open_quote) begin
            phase_in = PH_OPEN;
         end else if (pop_cmd.body != BODY_NONE) begin
            phase_in = PH_BODY;
         end else begin
            phase_in = PH_CLOSE;
         end
      end else if (emit && cmd_last) begin
         cur_valid_in = 1'b0;
      end else if (emit) begin
         if (seg_last) begin
            idx_in = 4'd0;
            if (phase_ff == PH_OPEN && cur_ff.body != BODY_NONE) begin
               phase_in = PH_BODY;
            end else begin
               phase_in = PH_CLOSE;
            end
         end else begin
            idx_in = idx_ff + 4'd1;
         end
      end
   end

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         phase_ff     <= PH_OPEN;
         idx_ff       <= 4'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_char_ff <= ch;
         run_end_ff  <= cmd_last;
         text_end_ff <= tend;
         bad_utf8_ff <= bad;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_char = out_char_ff;
   assign rsp.run_end  = run_end_ff;
   assign rsp.text_end = text_end_ff;
   assign rsp.bad_utf8 = bad_utf8_ff;

endmodule

FILE: rtl/json_string_escaper_unit.sv
// A command passes the queue, the back end's command register and its output register.
// Throughput: one JSON character per cycle while the output accepts them; a byte
// prints 1 body character as plain text, up to 13 as a surrogate pair and its quote.
// The front end takes a byte every cycle while the command queue has room.
// Reset is synchronous and active high; it clears both flags and empties all stages.
// Top level: front end, command queue and back end of the JSON string escaper.
module json_string_escaper_unit
   import jse_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   jse_req_if.sink   req,
   jse_rsp_if.source rsp,
   input  logic      csr_wr_en,
   input  logic      csr_index,
   input  logic      csr_data
);

   logic    push_valid, push_ready;
   logic    pop_valid, pop_ready;
   cmd_type push_cmd, pop_cmd;

   jse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   jse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   jse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp       (rsp)
   );

endmodule
